### sv/tfp_pkg.sv
// shared widths and the side-payload struct for the triangle face pipeline
// no dependencies
package tfp_pkg;

    localparam int CW   = 12;          // coordinate width
    localparam int EW   = CW + 1;      // edge vector width
    localparam int SUMW = CW + 2;      // sum of three coordinates
    localparam int PW   = 2 * EW;      // cross product partial product
    localparam int NW   = PW + 1;      // cross product component
    localparam int MW   = 25;          // magnitude of a cross component
    localparam int SW   = 52;          // squared length
    localparam int LW   = SW / 2;      // integer root
    localparam int QW   = 15;          // normal magnitude, at most 16384
    localparam int FRAC = 14;          // normal fraction bits
    localparam int NUMW = MW + FRAC;   // dividend width
    localparam int OW   = 16;          // normal output width
    localparam int AW   = LW - 1;      // area width
    localparam int RECW = 15;          // reciprocal of three, width
    localparam logic [RECW-1:0] RECIP3 = RECW'(21846);  // ceil(65536 / 3)
    localparam int RSH  = 16;

    typedef struct packed {
        logic [2:0]          neg;
        logic [2:0][MW-1:0]  mag;
        logic [2:0][CW-1:0]  center;
    } side_t;

endpackage

### sv/tfp_front.sv
// front stages: edges, cross product, squares, squared length and centroid
// depends on tfp_pkg
module tfp_front
    import tfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] a_x,
    input  logic signed [CW-1:0] a_y,
    input  logic signed [CW-1:0] a_z,
    input  logic signed [CW-1:0] b_x,
    input  logic signed [CW-1:0] b_y,
    input  logic signed [CW-1:0] b_z,
    input  logic signed [CW-1:0] c_x,
    input  logic signed [CW-1:0] c_y,
    input  logic signed [CW-1:0] c_z,
    output logic                 out_valid,
    output logic [SW-1:0]        sq,
    output side_t                side
);

    logic [4:0] vld_reg;

    logic signed [EW-1:0]   e1_reg [3];
    logic signed [EW-1:0]   e2_reg [3];
    logic signed [SUMW-1:0] s1_reg [3];

    logic signed [PW-1:0]   p_reg [3];
    logic signed [PW-1:0]   q_reg [3];
    logic [2:0]             cneg2_reg;
    logic [EW+RECW-1:0]     cprod_reg [3];

    side_t                  side3_reg;
    side_t                  side4_reg;
    side_t                  side5_reg;
    logic [2*MW-1:0]        sqc_reg [3];
    logic [SW-1:0]          sq_reg;

    logic signed [CW-1:0]   av [3];
    logic signed [CW-1:0]   bv [3];
    logic signed [CW-1:0]   cv [3];
    logic signed [NW-1:0]   n_next [3];
    logic [NW-1:0]          nabs [3];
    logic [EW-1:0]          cmag [3];
    logic [CW-1:0]          cq [3];
    side_t                  side3_next;

    assign av = '{a_x, a_y, a_z};
    assign bv = '{b_x, b_y, b_z};
    assign cv = '{c_x, c_y, c_z};

    always_comb
    begin
        side3_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            n_next[i] = NW'(p_reg[i]) - NW'(q_reg[i]);
            nabs[i]   = n_next[i][NW-1] ? NW'(-n_next[i]) : NW'(n_next[i]);
            side3_next.neg[i] = n_next[i][NW-1];
            side3_next.mag[i] = nabs[i][MW-1:0];
            cq[i] = CW'(cprod_reg[i] >> RSH);
            side3_next.center[i] = cneg2_reg[i] ? CW'(-cq[i]) : cq[i];
            cmag[i] = s1_reg[i][SUMW-1] ? EW'(-s1_reg[i]) : EW'(s1_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= EW'(bv[i]) - EW'(av[i]);
                e2_reg[i] <= EW'(cv[i]) - EW'(av[i]);
                s1_reg[i] <= SUMW'(av[i]) + SUMW'(bv[i]) + SUMW'(cv[i]);
                cneg2_reg[i] <= s1_reg[i][SUMW-1];
                cprod_reg[i] <= (EW+RECW)'(cmag[i]) * (EW+RECW)'(RECIP3);
                sqc_reg[i] <= (2*MW)'(side3_reg.mag[i]) * (2*MW)'(side3_reg.mag[i]);
            end
            p_reg[0] <= e1_reg[1] * e2_reg[2];
            q_reg[0] <= e1_reg[2] * e2_reg[1];
            p_reg[1] <= e1_reg[2] * e2_reg[0];
            q_reg[1] <= e1_reg[0] * e2_reg[2];
            p_reg[2] <= e1_reg[0] * e2_reg[1];
            q_reg[2] <= e1_reg[1] * e2_reg[0];
            side3_reg <= side3_next;
            side4_reg <= side3_reg;
            side5_reg <= side4_reg;
            sq_reg <= SW'(sqc_reg[0]) + SW'(sqc_reg[1]) + SW'(sqc_reg[2]);
        end
    end

    assign out_valid = vld_reg[4];
    assign sq        = sq_reg;
    assign side      = side5_reg;

endmodule

### sv/tfp_sqrt.sv
// integer square root, one result bit per register stage
// depends on tfp_pkg
module tfp_sqrt
    import tfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [SW-1:0] sq,
    input  side_t         in_side,
    output logic          out_valid,
    output logic [LW-1:0] root,
    output side_t         out_side
);

    logic [LW-1:0] vld_reg;
    logic [SW-1:0] rem_reg  [LW];
    logic [LW-1:0] root_reg [LW];
    side_t         side_reg [LW];

    for (genvar j = 0; j < LW; j++)
    begin : g_stage
        localparam int K = LW - 1 - j;
        logic          v_in;
        logic [SW-1:0] rem_in;
        logic [LW-1:0] root_in;
        side_t         side_in;
        logic [SW+1:0] trial;
        logic          ge;

        if (j == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = sq;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = vld_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        // root bits sit above bit K, so the two terms never overlap
        assign trial = ((SW+2)'(root_in) << (K + 1)) | ((SW+2)'(1) << (2 * K));
        assign ge    = (SW+2)'(rem_in) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= ge ? rem_in - trial[SW-1:0] : rem_in;
                root_reg[j] <= root_in | (LW'(ge) << K);
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[LW-1];
    assign root      = root_reg[LW-1];
    assign out_side  = side_reg[LW-1];

endmodule

### sv/tfp_div.sv
// three-lane restoring divider for the normal, one quotient bit per stage,
// plus the output register; depends on tfp_pkg
module tfp_div
    import tfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [LW-1:0]        len,
    input  side_t                in_side,
    output logic                 out_valid,
    output logic signed [OW-1:0] normal [3],
    output logic [CW-1:0]        center [3],
    output logic [AW-1:0]        area,
    output logic                 degenerate
);

    logic [QW-1:0]          vld_reg;
    logic [QW-1:0][2:0][NUMW-1:0] rem_reg;
    logic [QW-1:0][2:0][QW-1:0]   q_reg;
    logic [LW-1:0]          len_reg  [QW];
    side_t                  side_reg [QW];

    logic                   ovld_reg;
    logic signed [OW-1:0]   normal_reg [3];
    logic [CW-1:0]          center_reg [3];
    logic [AW-1:0]          area_reg;
    logic                   degen_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        localparam int K = QW - 1 - j;
        logic                   v_in;
        logic [2:0][NUMW-1:0]   rem_in;
        logic [2:0][QW-1:0]     q_in;
        logic [LW-1:0]          len_in;
        side_t                  side_in;
        logic [NUMW+1:0]        trial;
        logic [2:0][NUMW-1:0]   rem_nx;
        logic [2:0][QW-1:0]     q_nx;

        if (j == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign len_in  = len;
            assign side_in = in_side;
            for (genvar i = 0; i < 3; i++)
            begin : g_init
                assign rem_in[i] = {in_side.mag[i], {FRAC{1'b0}}};
                assign q_in[i]   = '0;
            end
        end
        else
        begin : g_rest
            assign v_in    = vld_reg[j-1];
            assign len_in  = len_reg[j-1];
            assign side_in = side_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign q_in    = q_reg[j-1];
        end

        assign trial = (NUMW+2)'(len_in) << K;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if ((NUMW+2)'(rem_in[i]) >= trial)
                begin
                    rem_nx[i] = rem_in[i] - trial[NUMW-1:0];
                    q_nx[i]   = q_in[i] | (QW'(1) << K);
                end
                else
                begin
                    rem_nx[i] = rem_in[i];
                    q_nx[i]   = q_in[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_nx;
                q_reg[j]    <= q_nx;
                len_reg[j]  <= len_in;
                side_reg[j] <= side_in;
            end
        end
    end

    logic zero_len;
    assign zero_len = (len_reg[QW-1] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (en)
            ovld_reg <= vld_reg[QW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (zero_len)
                    normal_reg[i] <= '0;
                else if (side_reg[QW-1].neg[i])
                    normal_reg[i] <= -OW'(q_reg[QW-1][i]);
                else
                    normal_reg[i] <= OW'(q_reg[QW-1][i]);
                center_reg[i] <= side_reg[QW-1].center[i];
            end
            area_reg  <= len_reg[QW-1][LW-1:1];
            degen_reg <= zero_len;
        end
    end

    assign out_valid  = ovld_reg;
    assign normal     = normal_reg;
    assign center     = center_reg;
    assign area       = area_reg;
    assign degenerate = degen_reg;

endmodule

### sv/triangle_face_properties.sv
// top level of the triangle face pipeline: normal, centroid and area
// depends on tfp_pkg, tfp_front, tfp_sqrt, tfp_div
//
//  channel   handshake            payload
//  input     in_valid / in_ready  a_x a_y a_z b_x b_y b_z c_x c_y c_z
//  output    out_valid/out_ready  normal_x/y/z center_x/y/z area degenerate
//
// one triangle enters per cycle unless a held output stalls it; the pipeline holds 5 front
// stages, 26 square-root stages, 15 divider stages and one output register
// the square-root and divider chains each resolve one bit per stage
// rst_n clears only the valid bits; payload registers are not reset
// a held output item stalls the whole pipeline; bubbles inside are not squeezed out
module triangle_face_properties
    import tfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] a_x,
    input  logic signed [CW-1:0] a_y,
    input  logic signed [CW-1:0] a_z,
    input  logic signed [CW-1:0] b_x,
    input  logic signed [CW-1:0] b_y,
    input  logic signed [CW-1:0] b_z,
    input  logic signed [CW-1:0] c_x,
    input  logic signed [CW-1:0] c_y,
    input  logic signed [CW-1:0] c_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [OW-1:0] normal_x,
    output logic signed [OW-1:0] normal_y,
    output logic signed [OW-1:0] normal_z,
    output logic signed [CW-1:0] center_x,
    output logic signed [CW-1:0] center_y,
    output logic signed [CW-1:0] center_z,
    output logic [AW-1:0]        area,
    output logic                 degenerate
);

    logic                 en;
    logic                 f_valid;
    logic [SW-1:0]        f_sq;
    side_t                f_side;
    logic                 r_valid;
    logic [LW-1:0]        r_root;
    side_t                r_side;
    logic signed [OW-1:0] normal [3];
    logic [CW-1:0]        center [3];

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    tfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .c_x       (c_x),
        .c_y       (c_y),
        .c_z       (c_z),
        .out_valid (f_valid),
        .sq        (f_sq),
        .side      (f_side)
    );

    tfp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .sq        (f_sq),
        .in_side   (f_side),
        .out_valid (r_valid),
        .root      (r_root),
        .out_side  (r_side)
    );

    tfp_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (r_valid),
        .len        (r_root),
        .in_side    (r_side),
        .out_valid  (out_valid),
        .normal     (normal),
        .center     (center),
        .area       (area),
        .degenerate (degenerate)
    );

    assign normal_x = normal[0];
    assign normal_y = normal[1];
    assign normal_z = normal[2];
    assign center_x = center[0];
    assign center_y = center[1];
    assign center_z = center[2];

endmodule
